[rtl/qmfp_pkg.sv]
// ----------------------------------------------------------------------------
// Quote message field parser package
// Shared types, character codes, message layouts and helper functions.
// ----------------------------------------------------------------------------
package qmfp_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	localparam int POS_W = 7;
	localparam int PRICE_W = 40;
	localparam int SIZE_W = 24;
	localparam int TIME_W = 13;
	localparam int SYM_MAX = 11;
	localparam int SYM_IDX_W = 4;

	localparam logic [7:0] CHAR_B = 8'h42;
	localparam logic [7:0] CHAR_D = 8'h44;
	localparam logic [7:0] CHAR_E = 8'h45;
	localparam logic [7:0] CHAR_L = 8'h4C;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	localparam logic [POS_W-1:0] POS_MAX = 7'd127;
	localparam logic [POS_W-1:0] TIME_FIRST = 7'd18;
	localparam logic [POS_W-1:0] TIME_LAST = 7'd21;
	localparam logic [POS_W-1:0] SYM_AT = 7'd24;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_UNKNOWN = 2'd1;
	localparam logic [1:0] ST_TRUNC = 2'd2;
	localparam logic [1:0] ST_BAD_DIGIT = 2'd3;

	typedef struct packed {
		logic [POS_W-1:0] sym_len;
		logic [POS_W-1:0] bden_at;
		logic [POS_W-1:0] bpx_at;
		logic [POS_W-1:0] bpx_len;
		logic [POS_W-1:0] bsz_at;
		logic [POS_W-1:0] bsz_len;
		logic [POS_W-1:0] oden_at;
		logic [POS_W-1:0] opx_at;
		logic [POS_W-1:0] opx_len;
		logic [POS_W-1:0] osz_at;
		logic [POS_W-1:0] osz_len;
		logic [POS_W-1:0] total;
	} layout_t;

	localparam layout_t SHORT_LAYOUT = '{7'd3, 7'd30, 7'd31, 7'd8, 7'd39, 7'd3,
		7'd43, 7'd44, 7'd8, 7'd52, 7'd3, 7'd58};
	localparam layout_t LONG_LAYOUT = '{7'd11, 7'd51, 7'd52, 7'd12, 7'd64, 7'd7,
		7'd71, 7'd72, 7'd12, 7'd84, 7'd7, 7'd102};

	typedef enum logic [3:0] {
		OP_NOP,
		OP_TIME,
		OP_SYM,
		OP_BDEN,
		OP_ODEN,
		OP_BPX,
		OP_OPX,
		OP_BSZ,
		OP_OSZ
	} op_kind_t;

	typedef struct packed {
		op_kind_t kind;
		logic [7:0] data;
		logic [3:0] digit;
		logic [TIME_W-1:0] time_term;
		logic [SYM_IDX_W-1:0] sym_idx;
		logic bad;
		logic last;
		logic [1:0] status;
		logic long_form;
		logic [7:0] category;
	} op_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic last_byte;
	} in_t;

	typedef struct packed {
		logic [1:0] status;
		logic long_form;
		logic [7:0] category_code;
		logic [63:0] symbol_head;
		logic [23:0] symbol_tail;
		logic [3:0] symbol_length;
		logic [PRICE_W-1:0] bid_quote;
		logic [SIZE_W-1:0] bid_size;
		logic [PRICE_W-1:0] offer_quote;
		logic [SIZE_W-1:0] offer_size;
		logic [15:0] price_denominators;
		logic [TIME_W-1:0] minute_of_day;
	} out_t;

	function automatic logic in_field(input logic [POS_W-1:0] p, input logic [POS_W-1:0] at,
			input logic [POS_W-1:0] len);
		logic [POS_W:0] stop;
		stop = {1'b0, at} + {1'b0, len};
		return (p >= at) && ({1'b0, p} < stop);
	endfunction

	function automatic logic [TIME_W-1:0] time_weight(input logic [1:0] idx);
		logic [TIME_W-1:0] w;
		case (idx)
			2'd0: w = 13'd600;
			2'd1: w = 13'd60;
			2'd2: w = 13'd10;
			default: w = 13'd1;
		endcase
		return w;
	endfunction

endpackage

[rtl/qmfp_front.sv]
// ----------------------------------------------------------------------------
// Quote message parser front end
// Accepts message bytes, tracks position and layout, and classifies each
// byte into an operation for the back end.
// ----------------------------------------------------------------------------
module qmfp_front (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	input  qmfp_pkg::in_t item,
	input  logic q_full,
	output logic push,
	output qmfp_pkg::op_t op
);

	logic [qmfp_pkg::POS_W-1:0] pos_q;
	logic [7:0] cat_q;
	logic [7:0] typ_q;

	logic [7:0] b;
	logic [7:0] cat_n;
	logic [7:0] typ_n;
	logic short_f;
	logic long_f;
	logic known;
	logic is_digit;
	logic digit_field;
	logic [7:0] digit_full;
	logic [qmfp_pkg::POS_W-1:0] time_off;
	logic [qmfp_pkg::POS_W-1:0] sym_off;
	logic [qmfp_pkg::POS_W:0] received;
	qmfp_pkg::layout_t lay;

	assign item_stall = q_full;
	assign push = item_valid && !q_full;

	always_comb begin
		b = item.data_byte;
		cat_n = (pos_q == '0) ? b : cat_q;
		typ_n = (pos_q == qmfp_pkg::POS_W'(1)) ? b : typ_q;
		short_f = (typ_n == qmfp_pkg::CHAR_D) &&
			((cat_n == qmfp_pkg::CHAR_E) || (cat_n == qmfp_pkg::CHAR_L));
		long_f = (typ_n == qmfp_pkg::CHAR_B) && ((cat_n == qmfp_pkg::CHAR_B) ||
			(cat_n == qmfp_pkg::CHAR_E) || (cat_n == qmfp_pkg::CHAR_L));
		known = short_f || long_f;
		lay = long_f ? qmfp_pkg::LONG_LAYOUT : qmfp_pkg::SHORT_LAYOUT;
		is_digit = (b >= qmfp_pkg::CHAR_ZERO) && (b <= qmfp_pkg::CHAR_NINE);
		digit_full = b - qmfp_pkg::CHAR_ZERO;
		time_off = pos_q - qmfp_pkg::TIME_FIRST;
		sym_off = pos_q - qmfp_pkg::SYM_AT;
		received = {1'b0, pos_q} + 8'd1;

		op = '0;
		op.kind = qmfp_pkg::OP_NOP;
		if (known && (pos_q >= qmfp_pkg::POS_W'(2))) begin
			if ((pos_q >= qmfp_pkg::TIME_FIRST) && (pos_q <= qmfp_pkg::TIME_LAST)) begin
				op.kind = qmfp_pkg::OP_TIME;
			end else if (qmfp_pkg::in_field(pos_q, qmfp_pkg::SYM_AT, lay.sym_len)) begin
				op.kind = qmfp_pkg::OP_SYM;
			end else if (pos_q == lay.bden_at) begin
				op.kind = qmfp_pkg::OP_BDEN;
			end else if (pos_q == lay.oden_at) begin
				op.kind = qmfp_pkg::OP_ODEN;
			end else if (qmfp_pkg::in_field(pos_q, lay.bpx_at, lay.bpx_len)) begin
				op.kind = qmfp_pkg::OP_BPX;
			end else if (qmfp_pkg::in_field(pos_q, lay.opx_at, lay.opx_len)) begin
				op.kind = qmfp_pkg::OP_OPX;
			end else if (qmfp_pkg::in_field(pos_q, lay.bsz_at, lay.bsz_len)) begin
				op.kind = qmfp_pkg::OP_BSZ;
			end else if (qmfp_pkg::in_field(pos_q, lay.osz_at, lay.osz_len)) begin
				op.kind = qmfp_pkg::OP_OSZ;
			end
		end

		digit_field = op.kind inside {qmfp_pkg::OP_TIME, qmfp_pkg::OP_BPX, qmfp_pkg::OP_OPX,
			qmfp_pkg::OP_BSZ, qmfp_pkg::OP_OSZ};
		op.data = b;
		op.digit = is_digit ? digit_full[3:0] : 4'd0;
		op.bad = digit_field && !is_digit;
		op.time_term = {9'd0, op.digit} * qmfp_pkg::time_weight(time_off[1:0]);
		op.sym_idx = sym_off[qmfp_pkg::SYM_IDX_W-1:0];
		op.last = item.last_byte;
		op.long_form = long_f;
		op.category = cat_n;
		if (!known) begin
			op.status = qmfp_pkg::ST_UNKNOWN;
		end else if (received < {1'b0, lay.total}) begin
			op.status = qmfp_pkg::ST_TRUNC;
		end else begin
			op.status = qmfp_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			cat_q <= '0;
			typ_q <= '0;
		end else if (push) begin
			if (item.last_byte) begin
				pos_q <= '0;
				cat_q <= '0;
				typ_q <= '0;
			end else begin
				if (pos_q != qmfp_pkg::POS_MAX) begin
					pos_q <= pos_q + qmfp_pkg::POS_W'(1);
				end
				cat_q <= cat_n;
				typ_q <= typ_n;
			end
		end
	end

	a_pos_clear: assert property (@(posedge clk) disable iff (!arst_n)
		push && item.last_byte |=> pos_q == '0 && cat_q == '0 && typ_q == '0)
		else $error("position not cleared after final byte");

	a_unknown_nop: assert property (@(posedge clk) disable iff (!arst_n)
		op.status == qmfp_pkg::ST_UNKNOWN |-> op.kind == qmfp_pkg::OP_NOP && !op.bad)
		else $error("operation issued for unknown message type");

	a_sym_range: assert property (@(posedge clk) disable iff (!arst_n)
		op.kind == qmfp_pkg::OP_SYM |-> op.sym_idx < qmfp_pkg::SYM_IDX_W'(qmfp_pkg::SYM_MAX))
		else $error("symbol index out of range");

endmodule

[rtl/qmfp_queue.sv]
// ----------------------------------------------------------------------------
// Quote message parser operation queue
// Short first-in first-out queue that decouples the front and back ends.
// ----------------------------------------------------------------------------
module qmfp_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  qmfp_pkg::op_t push_op,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output qmfp_pkg::op_t head_op
);

	qmfp_pkg::op_t entry_q [qmfp_pkg::QDEPTH];
	logic [qmfp_pkg::QAW-1:0] wr_ptr_q;
	logic [qmfp_pkg::QAW-1:0] rd_ptr_q;
	logic [qmfp_pkg::QAW:0] count_q;

	assign full = (count_q == (qmfp_pkg::QAW+1)'(qmfp_pkg::QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_op = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + qmfp_pkg::QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + qmfp_pkg::QAW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (qmfp_pkg::QAW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (qmfp_pkg::QAW+1)'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |-> count_q <= (qmfp_pkg::QAW+1)'(qmfp_pkg::QDEPTH))
		else $error("queue count above depth");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from empty queue");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> !full)
		else $error("push into full queue");

endmodule

[rtl/qmfp_back.sv]
// ----------------------------------------------------------------------------
// Quote message parser back end
// Executes classified operations on the field accumulators and builds the
// record in an output register on the final byte of each message.
// ----------------------------------------------------------------------------
module qmfp_back (
	input  logic clk,
	input  logic arst_n,
	input  logic op_valid,
	input  qmfp_pkg::op_t op,
	output logic pop,
	output logic rec_valid,
	input  logic rec_stall,
	output qmfp_pkg::out_t rec
);

	logic [7:0] sym_q [qmfp_pkg::SYM_MAX];
	logic [qmfp_pkg::SYM_IDX_W-1:0] count_q;
	logic space_q;
	logic [qmfp_pkg::PRICE_W-1:0] bpx_q;
	logic [qmfp_pkg::PRICE_W-1:0] opx_q;
	logic [qmfp_pkg::SIZE_W-1:0] bsz_q;
	logic [qmfp_pkg::SIZE_W-1:0] osz_q;
	logic [15:0] den_q;
	logic [qmfp_pkg::TIME_W-1:0] time_q;
	logic bad_q;
	logic rec_valid_q;
	qmfp_pkg::out_t rec_q;

	logic [7:0] sym_n [qmfp_pkg::SYM_MAX];
	logic [qmfp_pkg::SYM_IDX_W-1:0] count_n;
	logic space_n;
	logic [qmfp_pkg::PRICE_W-1:0] bpx_n;
	logic [qmfp_pkg::PRICE_W-1:0] opx_n;
	logic [qmfp_pkg::SIZE_W-1:0] bsz_n;
	logic [qmfp_pkg::SIZE_W-1:0] osz_n;
	logic [15:0] den_n;
	logic [qmfp_pkg::TIME_W-1:0] time_n;
	logic bad_n;
	qmfp_pkg::out_t rec_n;

	assign pop = op_valid && (!op.last || !rec_valid_q || !rec_stall);
	assign rec_valid = rec_valid_q;
	assign rec = rec_q;

	always_comb begin
		sym_n = sym_q;
		count_n = count_q;
		space_n = space_q;
		bpx_n = bpx_q;
		opx_n = opx_q;
		bsz_n = bsz_q;
		osz_n = osz_q;
		den_n = den_q;
		time_n = time_q + op.time_term;
		bad_n = bad_q | op.bad;
		if (op.kind != qmfp_pkg::OP_TIME) begin
			time_n = time_q;
		end
		case (op.kind)
			qmfp_pkg::OP_SYM: begin
				if (!space_q) begin
					if (op.data == qmfp_pkg::CHAR_SPACE) begin
						space_n = 1'b1;
					end else begin
						sym_n[op.sym_idx] = op.data;
						count_n = op.sym_idx + qmfp_pkg::SYM_IDX_W'(1);
					end
				end
			end
			qmfp_pkg::OP_BDEN: den_n = {op.data, den_q[7:0]};
			qmfp_pkg::OP_ODEN: den_n = {den_q[15:8], op.data};
			qmfp_pkg::OP_BPX: bpx_n = (bpx_q << 3) + (bpx_q << 1) +
				{{(qmfp_pkg::PRICE_W-4){1'b0}}, op.digit};
			qmfp_pkg::OP_OPX: opx_n = (opx_q << 3) + (opx_q << 1) +
				{{(qmfp_pkg::PRICE_W-4){1'b0}}, op.digit};
			qmfp_pkg::OP_BSZ: bsz_n = (bsz_q << 3) + (bsz_q << 1) +
				{{(qmfp_pkg::SIZE_W-4){1'b0}}, op.digit};
			qmfp_pkg::OP_OSZ: osz_n = (osz_q << 3) + (osz_q << 1) +
				{{(qmfp_pkg::SIZE_W-4){1'b0}}, op.digit};
			default: ;
		endcase

		rec_n = '0;
		for (int i = 0; i < 8; i++) begin
			rec_n.symbol_head[63-8*i -: 8] =
				(qmfp_pkg::SYM_IDX_W'(i) < count_n) ? sym_n[i] : 8'd0;
		end
		for (int i = 8; i < qmfp_pkg::SYM_MAX; i++) begin
			rec_n.symbol_tail[23-8*(i-8) -: 8] =
				(qmfp_pkg::SYM_IDX_W'(i) < count_n) ? sym_n[i] : 8'd0;
		end
		rec_n.status = (op.status != qmfp_pkg::ST_OK) ? op.status :
			(bad_n ? qmfp_pkg::ST_BAD_DIGIT : qmfp_pkg::ST_OK);
		rec_n.long_form = op.long_form;
		rec_n.category_code = op.category;
		rec_n.symbol_length = count_n;
		rec_n.bid_quote = bpx_n;
		rec_n.bid_size = bsz_n;
		rec_n.offer_quote = opx_n;
		rec_n.offer_size = osz_n;
		rec_n.price_denominators = den_n;
		rec_n.minute_of_day = time_n;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sym_q <= sym_n;
		end
		if (pop && op.last) begin
			rec_q <= rec_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			space_q <= 1'b0;
			bpx_q <= '0;
			opx_q <= '0;
			bsz_q <= '0;
			osz_q <= '0;
			den_q <= '0;
			time_q <= '0;
			bad_q <= 1'b0;
			rec_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (op.last) begin
					count_q <= '0;
					space_q <= 1'b0;
					bpx_q <= '0;
					opx_q <= '0;
					bsz_q <= '0;
					osz_q <= '0;
					den_q <= '0;
					time_q <= '0;
					bad_q <= 1'b0;
				end else begin
					count_q <= count_n;
					space_q <= space_n;
					bpx_q <= bpx_n;
					opx_q <= opx_n;
					bsz_q <= bsz_n;
					osz_q <= osz_n;
					den_q <= den_n;
					time_q <= time_n;
					bad_q <= bad_n;
				end
			end
			if (pop && op.last) begin
				rec_valid_q <= 1'b1;
			end else if (!rec_stall) begin
				rec_valid_q <= 1'b0;
			end
		end
	end

	a_record_out: assert property (@(posedge clk) disable iff (!arst_n)
		pop && op.last |=> rec_valid_q)
		else $error("record not presented after final byte");

	a_state_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		pop && op.last |=> count_q == '0 && !bad_q && !space_q && time_q == '0)
		else $error("message state not cleared after record");

	a_unknown_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid_q && rec_q.status == qmfp_pkg::ST_UNKNOWN |->
		rec_q.symbol_length == '0 && rec_q.bid_quote == '0 && rec_q.minute_of_day == '0)
		else $error("unknown message carries captured fields");

endmodule

[rtl/quote_message_field_parser_core.sv]
// ----------------------------------------------------------------------------
// Quote message field parser
// Parses fixed-layout ASCII quote messages, one byte per request, into one
// record per message.
// ----------------------------------------------------------------------------
// The item channel carries one message byte and a final-byte mark per
// request; a request is taken when item_valid is high and item_stall low.
// The rec channel carries one parsed record per message, presented once the
// back end has applied the final byte, and held while rec_stall is high.
// The block takes one byte every cycle while item_stall is low. A byte is
// classified in the cycle it is taken, waits in a four-entry queue, and is
// applied by the back end to the field accumulators. The final byte passes
// through the queue to the back end, which registers the record.
// While rec_stall holds a finished record, bytes of the next message keep
// flowing through the back end; only a second final byte waits, and the
// queue then fills, after which item_stall rises.
// Reset clears the byte position, the queue, the back-end accumulators and
// the record valid flag; the block is ready for the first byte of a message
// as soon as reset is released.
// ----------------------------------------------------------------------------
module quote_message_field_parser_core (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	input  qmfp_pkg::in_t item,
	output logic rec_valid,
	input  logic rec_stall,
	output qmfp_pkg::out_t rec
);

	logic push;
	logic q_full;
	logic pop;
	logic head_valid;
	qmfp_pkg::op_t push_op;
	qmfp_pkg::op_t head_op;

	qmfp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.q_full(q_full),
		.push(push),
		.op(push_op)
	);

	qmfp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_op(push_op),
		.full(q_full),
		.pop(pop),
		.head_valid(head_valid),
		.head_op(head_op)
	);

	qmfp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.op_valid(head_valid),
		.op(head_op),
		.pop(pop),
		.rec_valid(rec_valid),
		.rec_stall(rec_stall),
		.rec(rec)
	);

endmodule
